// ----- hdl/obb_obb_overlap_sat_unit_macros.svh -----
// Assertion macros for the oriented box overlap unit
`ifndef OBB_OBB_OVERLAP_SAT_UNIT_MACROS_SVH
`define OBB_OBB_OVERLAP_SAT_UNIT_MACROS_SVH
// assert that a implies b on the same edge
`define OBB_ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// assert that a implies b on the next edge
`define OBB_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// ----- hdl/obbsat_pkg.sv -----
// Package with shared types and constants for the oriented box overlap unit
package obbsat_pkg;
	localparam int CW = 24;
	localparam int AW = 16;
	localparam int XW = AW + 1;
	localparam int SW = 23;
	localparam int FRAC_SHIFT = 15;
	localparam int DW = CW + 1;

	// One item as classified by the front part; axes carry one extra bit so
	// that negating the most negative axis component does not wrap
	typedef struct packed {
		logic signed [XW-1:0] ax0, ay0, ax1, ay1, ax2, ay2, ax3, ay3;
		logic [SW-1:0] e0, e1, e2, e3;
		logic signed [DW-1:0] dx, dy;
	} item_t;

	// Queue status between two modules
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;
endpackage

// ----- hdl/obbsat_front.sv -----
// Front part: accepts an item, forms axes and centre distance, queues it
module obbsat_front #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [obbsat_pkg::CW-1:0] a_center_x, a_center_y, b_center_x, b_center_y,
	input  logic [obbsat_pkg::AW-1:0] a_right_x, a_right_y, b_right_x, b_right_y,
	input  logic [obbsat_pkg::SW-1:0] a_width, a_height, b_width, b_height,
	input  logic take,
	output obbsat_pkg::item_t item,
	output obbsat_pkg::qstat_t stat
);
	localparam int PW = $clog2(DEPTH);
	obbsat_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;
	obbsat_pkg::item_t nx;
	logic wr, rd;

	// Classify: derive up axes and centre distance
	always_comb begin
		nx.ax0 = $signed({a_right_x[obbsat_pkg::AW-1], a_right_x});
		nx.ay0 = $signed({a_right_y[obbsat_pkg::AW-1], a_right_y});
		nx.ax1 = -$signed({a_right_y[obbsat_pkg::AW-1], a_right_y});
		nx.ay1 = $signed({a_right_x[obbsat_pkg::AW-1], a_right_x});
		nx.ax2 = $signed({b_right_x[obbsat_pkg::AW-1], b_right_x});
		nx.ay2 = $signed({b_right_y[obbsat_pkg::AW-1], b_right_y});
		nx.ax3 = -$signed({b_right_y[obbsat_pkg::AW-1], b_right_y});
		nx.ay3 = $signed({b_right_x[obbsat_pkg::AW-1], b_right_x});
		nx.e0 = a_width;
		nx.e1 = a_height;
		nx.e2 = b_width;
		nx.e3 = b_height;
		nx.dx = $signed({a_center_x[obbsat_pkg::CW-1], a_center_x})
			- $signed({b_center_x[obbsat_pkg::CW-1], b_center_x});
		nx.dy = $signed({a_center_y[obbsat_pkg::CW-1], a_center_y})
			- $signed({b_center_y[obbsat_pkg::CW-1], b_center_y});
	end

	assign stat.full = (cnt_q == (PW+1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign wr = push && !stat.full;
	assign rd = take && !stat.empty;
	assign item = mem_q[rp_q];

	// Store beats
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= nx;
		end
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
		end
	end
endmodule

// ----- hdl/obbsat_back.sv -----
// Back part: pipelined separating axis evaluation with output queue
module obbsat_back #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  obbsat_pkg::item_t item,
	input  logic item_valid,
	output logic take,
	input  logic pop,
	output logic empty,
	output logic overlap
);
	localparam int PW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 4);
	// axis-axis dot: 33 bits signed; distance dot: 42 bits signed
	logic signed [32:0] dot_s1 [4][4];
	logic signed [41:0] dd_s1 [4];
	logic [obbsat_pkg::SW-1:0] e_s1 [4];
	logic [55:0] pr_s2 [4][4];
	logic [40:0] dm_s2 [4];
	logic [57:0] sum_s3 [4];
	logic [57:0] dist_s3 [4];
	logic v_s1, v_s2, v_s3;
	logic signed [obbsat_pkg::XW-1:0] ax [4], ay [4];
	logic [CNTW-1:0] inflight;
	logic res_mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;
	logic hit;
	logic wr, rd;

	assign ax = '{item.ax0, item.ax1, item.ax2, item.ax3};
	assign ay = '{item.ay0, item.ay1, item.ay2, item.ay3};

	// Take a beat only while the result queue has room for all in flight,
	// counting the slot freed by a pop on this edge
	assign inflight = CNTW'(cnt_q) + CNTW'(v_s1) + CNTW'(v_s2) + CNTW'(v_s3);
	assign take = item_valid && (inflight < CNTW'(DEPTH) + CNTW'(rd));

	// Stage one: dot products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				dot_s1[i][j] <= 33'(ax[i] * ax[j]) + 33'(ay[i] * ay[j]);
			end
			dd_s1[i] <= 42'(ax[i] * item.dx) + 42'(ay[i] * item.dy);
		end
		e_s1 <= '{item.e0, item.e1, item.e2, item.e3};
	end

	// Stage two: magnitudes times extents
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				pr_s2[i][j] <= 56'(33'(dot_s1[i][j] < 0 ? -dot_s1[i][j] : dot_s1[i][j]))
					* 56'(e_s1[j]);
			end
			dm_s2[i] <= 41'(dd_s1[i] < 0 ? -dd_s1[i] : dd_s1[i]);
		end
	end

	// Stage three: sums and scaled distance
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			sum_s3[i] <= 58'(pr_s2[i][0]) + 58'(pr_s2[i][1])
				+ 58'(pr_s2[i][2]) + 58'(pr_s2[i][3]);
			dist_s3[i] <= 58'(dm_s2[i]) << obbsat_pkg::FRAC_SHIFT;
		end
	end

	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (sum_s3[i] < dist_s3[i]) hit = 1'b0;
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign wr = v_s3;
	assign empty = (cnt_q == '0);
	assign rd = pop && !empty;
	assign overlap = res_mem_q[rp_q];

	// Hold results until popped
	always_ff @(posedge clk) begin
		if (wr) res_mem_q[wp_q] <= hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
		end
	end
endmodule

// ----- hdl/obb_obb_overlap_sat_unit.sv -----
// Oriented box overlap unit by separating axis test, 2D, fixed point.
// Input channel: drive the twelve box fields and raise push; a beat is
// taken at an edge where push is high and full is low.
// Result channel: while empty is low, overlap shows the oldest result;
// raise pop to take it. overlap is 1 unless some axis separates the boxes.
// Boxes that just touch count as overlapping.
// Throughput: one item per cycle while pop keeps up.
// From the input beat to empty falling, a result passes the input queue,
// then the three pipeline stages, then the result queue; the back may
// leave a beat waiting in the input queue while it has no room.
// The front queue holds IN_DEPTH beats; the back keeps OUT_DEPTH results
// reserved for work in flight, so a stalled receiver fills the result
// queue, then the input queue, and then full rises; nothing is lost.
// Reset clears both queues and the pipeline valids; it takes effect at
// once and no clearing pass follows.
// Arithmetic is exact: no rounding, no saturation.
// Stage one multiplies 17 by 17 and 17 by 25 bits; stage two, 33 by 23.
// Order of the result beats equals the order of the input beats.
// Parameters set only the depth of the two queues.
`include "obb_obb_overlap_sat_unit_macros.svh"
module obb_obb_overlap_sat_unit #(
	parameter int IN_DEPTH = 4,
	parameter int OUT_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [23:0] a_center_x,
	input  logic [23:0] a_center_y,
	input  logic [15:0] a_right_x,
	input  logic [15:0] a_right_y,
	input  logic [22:0] a_width,
	input  logic [22:0] a_height,
	input  logic [23:0] b_center_x,
	input  logic [23:0] b_center_y,
	input  logic [15:0] b_right_x,
	input  logic [15:0] b_right_y,
	input  logic [22:0] b_width,
	input  logic [22:0] b_height,
	output logic empty,
	input  logic pop,
	output logic overlap
);
	obbsat_pkg::item_t item;
	obbsat_pkg::qstat_t stat;
	logic take;

	// Front: accept and classify
	obbsat_front #(.DEPTH(IN_DEPTH)) u_front (
		.clk, .arst_n, .push,
		.a_center_x, .a_center_y, .b_center_x, .b_center_y,
		.a_right_x, .a_right_y, .b_right_x, .b_right_y,
		.a_width, .a_height, .b_width, .b_height,
		.take, .item, .stat
	);

	// Back: evaluate axes
	obbsat_back #(.DEPTH(OUT_DEPTH)) u_back (
		.clk, .arst_n, .item, .item_valid(!stat.empty), .take,
		.pop, .empty, .overlap
	);

	assign full = stat.full;

	`OBB_ASSERT_IMPL(a_take_needs_item, clk, arst_n, take, !stat.empty)
	`OBB_ASSERT_NEXT(a_push_fills, clk, arst_n, push && !full, !stat.empty)
	`OBB_ASSERT_NEXT(a_empty_holds, clk, arst_n, empty && !u_back.v_s3, empty)
endmodule
